// ===== sv/yuv420_nearest_downscaler_unit_macros.svh =====
// Assertion macros shared by the downscaler checker.
`ifndef YUV420_NEAREST_DOWNSCALER_UNIT_MACROS_SVH
`define YUV420_NEAREST_DOWNSCALER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define NDSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define NDSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ndsc_pkg.sv =====
// Shared types and constants of the YUV420 nearest-neighbor downscaler.
package ndsc_pkg;

  localparam int DIM_W       = 13;
  localparam int STRIDE_W    = 14;
  localparam int PIX_W       = 8;
  localparam int PLANE_W     = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 14;
  localparam int PROD_W      = 2 * DIM_W;
  localparam int QUEUE_DEPTH = 4;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_STRIDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd4;

  // Register reset values
  localparam logic [DIM_W-1:0]    RST_SOURCE_WIDTH  = 13'd1920;
  localparam logic [DIM_W-1:0]    RST_SOURCE_HEIGHT = 13'd1080;
  localparam logic [STRIDE_W-1:0] RST_SOURCE_STRIDE = 14'd1920;
  localparam logic [DIM_W-1:0]    RST_TARGET_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]    RST_TARGET_HEIGHT = 13'd480;

  // Plane codes
  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

  // One result word
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [PLANE_W-1:0] plane;
    logic               last;
  } ndsc_word_t;

  // Effective luma geometry after clamping
  typedef struct packed {
    logic [DIM_W-1:0]    sw;
    logic [DIM_W-1:0]    sh;
    logic [STRIDE_W-1:0] st;
    logic [DIM_W-1:0]    dw;
    logic [DIM_W-1:0]    dh;
  } ndsc_geom_t;

  // Request to the position divider: mul_a * mul_b / den
  typedef struct packed {
    logic             start;
    logic [DIM_W-1:0] mul_a;
    logic [DIM_W-1:0] mul_b;
    logic [DIM_W-1:0] den;
  } ndsc_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIM_W-1:0] quot;
  } ndsc_div_rsp_t;

endpackage

// ===== sv/ndsc_div.sv =====
// Serial multiply-then-divide unit that computes the next selected position.
module ndsc_div import ndsc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  ndsc_div_req_t div_req,
  output ndsc_div_rsp_t div_rsp
);

  localparam int CNT_W = $clog2(DIM_W);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_MUL  = 3'b010,
    D_STEP = 3'b100
  } div_state_t;

  div_state_t       state_r, state_nxt;
  logic [DIM_W-1:0] a_r, a_nxt, b_r, b_nxt, den_r, den_nxt;
  logic [DIM_W-1:0] rem_r, rem_nxt, low_r, low_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;

  logic [PROD_W-1:0] prod;
  logic [DIM_W:0]    trial, diff;
  logic              ge;

  // Product of the latched operands
  assign prod = PROD_W'(a_r) * PROD_W'(b_r);

  // One restoring division step: bring down the next dividend bit
  assign trial = {rem_r, low_r[DIM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    low_nxt   = low_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      D_IDLE: begin
        if (div_req.start) begin
          a_nxt     = div_req.mul_a;
          b_nxt     = div_req.mul_b;
          den_nxt   = div_req.den;
          state_nxt = D_MUL;
        end
      end
      D_MUL: begin
        // Quotient fits DIM_W bits, so the high half is already below den
        rem_nxt   = prod[PROD_W-1:DIM_W];
        low_nxt   = prod[DIM_W-1:0];
        cnt_nxt   = '0;
        state_nxt = D_STEP;
      end
      D_STEP: begin
        rem_nxt = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
        low_nxt = {low_r[DIM_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIM_W - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    low_r <= low_nxt;
  end

  assign div_rsp.done = done_r;
  assign div_rsp.quot = low_r;

endmodule

// ===== sv/ndsc_front.sv =====
// Front end: tracks the source position, selects bytes and queues result words.
module ndsc_front import ndsc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ndsc_geom_t       geom,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_pixel_in,
  input  logic             in_frame_start,
  output ndsc_div_req_t    div_req,
  input  ndsc_div_rsp_t    div_rsp,
  input  logic             queue_full,
  output logic             push,
  output ndsc_word_t       push_word
);

  typedef enum logic [1:0] {
    F_RUN  = 2'b01,
    F_WAIT = 2'b10
  } front_state_t;

  front_state_t        state_r, state_nxt;
  logic                tgt_row_r, tgt_row_nxt;
  logic [PLANE_W-1:0]  plane_r, plane_nxt;
  logic [STRIDE_W-1:0] sc_r, sc_nxt;
  logic [DIM_W-1:0]    sr_r, sr_nxt, dc_r, dc_nxt, dr_r, dr_nxt;
  logic [DIM_W-1:0]    wc_r, wc_nxt, wr_r, wr_nxt;

  // Position as seen by this word, after a frame-start resync
  logic [PLANE_W-1:0]  plane_e;
  logic [STRIDE_W-1:0] sc_e;
  logic [DIM_W-1:0]    sr_e, dc_e, dr_e, wc_e, wr_e;

  logic                luma;
  logic [DIM_W-1:0]    pw, ph, qw, qh;
  logic [STRIDE_W-1:0] ps;
  logic [STRIDE_W:0]   sc_inc;
  logic [DIM_W:0]      sr_inc;
  logic [DIM_W-1:0]    dc_inc, dr_inc;
  logic                accept, row_sel, hit, row_end, plane_end, col_div, row_div;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == F_RUN) && !queue_full;

  // Resync on frame start
  always_comb begin
    if (in_frame_start) begin
      plane_e = PLANE_Y;
      sc_e    = '0;
      sr_e    = '0;
      dc_e    = '0;
      dr_e    = '0;
      wc_e    = '0;
      wr_e    = '0;
    end else begin
      plane_e = plane_r;
      sc_e    = sc_r;
      sr_e    = sr_r;
      dc_e    = dc_r;
      dr_e    = dr_r;
      wc_e    = wc_r;
      wr_e    = wr_r;
    end
  end

  // Plane sizes: chroma uses halved geometry
  assign luma = (plane_e == PLANE_Y);
  assign pw   = luma ? geom.sw : (geom.sw >> 1);
  assign ph   = luma ? geom.sh : (geom.sh >> 1);
  assign ps   = luma ? geom.st : (geom.st >> 1);
  assign qw   = luma ? geom.dw : (geom.dw >> 1);
  assign qh   = luma ? geom.dh : (geom.dh >> 1);

  // Classify the word
  assign sc_inc    = {1'b0, sc_e} + (STRIDE_W + 1)'(1);
  assign sr_inc    = {1'b0, sr_e} + (DIM_W + 1)'(1);
  assign dc_inc    = dc_e + 1'b1;
  assign dr_inc    = dr_e + 1'b1;
  assign row_sel   = (sr_e == wr_e) && (dr_e < qh);
  assign hit       = row_sel && (sc_e == {1'b0, wc_e}) && (dc_e < qw);
  assign row_end   = sc_inc >= {1'b0, ps};
  assign plane_end = row_end && (sr_inc >= {1'b0, ph});
  assign col_div   = hit && !row_end && (dc_inc < qw);
  assign row_div   = row_end && row_sel && !plane_end && (dr_inc < qh);

  // Queue the selected byte
  assign push            = accept && hit;
  assign push_word.pixel = in_pixel_in;
  assign push_word.plane = plane_e;
  assign push_word.last  = (plane_e == PLANE_V) && (dr_e == qh - 1'b1) &&
                           (dc_e == qw - 1'b1);

  // Start the next-position computation
  assign div_req.start = accept && (col_div || row_div);
  assign div_req.mul_a = row_div ? dr_inc : dc_inc;
  assign div_req.mul_b = row_div ? ph : pw;
  assign div_req.den   = row_div ? qh : qw;

  // Advance the position
  always_comb begin
    state_nxt   = state_r;
    tgt_row_nxt = tgt_row_r;
    plane_nxt   = plane_r;
    sc_nxt      = sc_r;
    sr_nxt      = sr_r;
    dc_nxt      = dc_r;
    dr_nxt      = dr_r;
    wc_nxt      = wc_r;
    wr_nxt      = wr_r;
    unique case (state_r)
      F_RUN: begin
        if (accept) begin
          plane_nxt = plane_e;
          sc_nxt    = row_end ? '0 : sc_inc[STRIDE_W-1:0];
          sr_nxt    = sr_e;
          dc_nxt    = hit ? dc_inc : dc_e;
          dr_nxt    = dr_e;
          wc_nxt    = wc_e;
          wr_nxt    = wr_e;
          if (row_end) begin
            if (row_sel) begin
              dr_nxt = dr_inc;
              dc_nxt = '0;
              wc_nxt = '0;
            end
            if (plane_end) begin
              sr_nxt    = '0;
              dc_nxt    = '0;
              dr_nxt    = '0;
              wc_nxt    = '0;
              wr_nxt    = '0;
              plane_nxt = (plane_e >= PLANE_V) ? PLANE_Y : plane_e + 1'b1;
            end else begin
              sr_nxt = sr_inc[DIM_W-1:0];
            end
          end
          if (col_div || row_div) begin
            tgt_row_nxt = row_div;
            state_nxt   = F_WAIT;
          end
        end
      end
      F_WAIT: begin
        if (div_rsp.done) begin
          if (tgt_row_r) begin
            wr_nxt = div_rsp.quot;
          end else begin
            wc_nxt = div_rsp.quot;
          end
          state_nxt = F_RUN;
        end
      end
      default: state_nxt = F_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_RUN;
      tgt_row_r <= 1'b0;
      plane_r   <= PLANE_Y;
      sc_r      <= '0;
      sr_r      <= '0;
      dc_r      <= '0;
      dr_r      <= '0;
      wc_r      <= '0;
      wr_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      tgt_row_r <= tgt_row_nxt;
      plane_r   <= plane_nxt;
      sc_r      <= sc_nxt;
      sr_r      <= sr_nxt;
      dc_r      <= dc_nxt;
      dr_r      <= dr_nxt;
      wc_r      <= wc_nxt;
      wr_r      <= wr_nxt;
    end
  end

endmodule

// ===== sv/ndsc_fifo.sv =====
// Short word queue between the front end and the output stage.
module ndsc_fifo import ndsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ndsc_word_t push_word,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output ndsc_word_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ndsc_word_t       mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

// ===== sv/ndsc_back.sv =====
// Output stage: pops queued words into the registered result channel.
module ndsc_back import ndsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ndsc_word_t         head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_pixel_out,
  output logic [PLANE_W-1:0] out_plane_out,
  output logic               out_frame_last
);

  logic       valid_r, valid_nxt;
  ndsc_word_t word_r;

  // Load when the register is free or being drained
  assign pop = !empty && (!valid_r || out_ready);

  always_comb begin
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the word until taken
  always_ff @(posedge clk) begin
    if (pop) begin
      word_r <= head;
    end
  end

  assign out_valid      = valid_r;
  assign out_pixel_out  = word_r.pixel;
  assign out_plane_out  = word_r.plane;
  assign out_frame_last = word_r.last;

endmodule

// ===== sv/yuv420_nearest_downscaler_unit.sv =====
// Top level of the planar YUV420 nearest-neighbor downscaler.
// Feed the source frame one byte per word in memory order (Y rows of the
// stride, then U and V rows of half the stride); the block passes on the byte
// at column floor(dx*W/w) of row floor(dy*H/h) of each plane, tagged with its
// plane and a flag on the last V byte of the destination frame. Sizes are
// clamped, made even, and the target is limited to the source. A byte that
// moves the selection to a new column or row holds the input until the shared
// multiply and 13-step serial divider has computed the next selected position;
// other bytes pass whenever the queue has room. A four-word queue and
// an output register decouple the input from the result channel.
module yuv420_nearest_downscaler_unit import ndsc_pkg::*; #(
  parameter int MAX_DIMENSION = 4096,
  parameter int MAX_STRIDE    = 8192
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel_in,
  input  logic                  in_frame_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_pixel_out,
  output logic [PLANE_W-1:0]    out_plane_out,
  output logic                  out_frame_last
);

  localparam int DIM_TOP    = (1 << DIM_W) - 1;
  localparam int STRIDE_TOP = (1 << STRIDE_W) - 1;
  localparam int DIM_CAP    = (MAX_DIMENSION > DIM_TOP) ? DIM_TOP : MAX_DIMENSION;
  localparam int STRIDE_CAP = (MAX_STRIDE > STRIDE_TOP) ? STRIDE_TOP : MAX_STRIDE;
  localparam logic [STRIDE_W-1:0] DIM_HI    = STRIDE_W'(DIM_CAP);
  localparam logic [STRIDE_W-1:0] STRIDE_HI = STRIDE_W'(STRIDE_CAP);

  function automatic logic [STRIDE_W-1:0] even_clamp(input logic [STRIDE_W-1:0] v,
                                                     input logic [STRIDE_W-1:0] hi);
    logic [STRIDE_W-1:0] t;
    t = (v > hi) ? hi : v;
    if (t < STRIDE_W'(2)) begin
      t = STRIDE_W'(2);
    end
    return {t[STRIDE_W-1:1], 1'b0};
  endfunction

  logic [DIM_W-1:0]    src_width_r, src_height_r, tgt_width_r, tgt_height_r;
  logic [STRIDE_W-1:0] src_stride_r;
  logic [STRIDE_W-1:0] sw_c, sh_c, st_c, dw_c, dh_c;
  ndsc_geom_t          geom;
  ndsc_div_req_t       div_req;
  ndsc_div_rsp_t       div_rsp;
  ndsc_word_t          push_word, head;
  logic                push, pop, queue_full, queue_empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= RST_SOURCE_WIDTH;
      src_height_r <= RST_SOURCE_HEIGHT;
      src_stride_r <= RST_SOURCE_STRIDE;
      tgt_width_r  <= RST_TARGET_WIDTH;
      tgt_height_r <= RST_TARGET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  src_width_r  <= cfg_data[DIM_W-1:0];
        REG_SOURCE_HEIGHT: src_height_r <= cfg_data[DIM_W-1:0];
        REG_SOURCE_STRIDE: src_stride_r <= cfg_data[STRIDE_W-1:0];
        REG_TARGET_WIDTH:  tgt_width_r  <= cfg_data[DIM_W-1:0];
        REG_TARGET_HEIGHT: tgt_height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to range and make even
  assign sw_c = even_clamp({1'b0, src_width_r}, DIM_HI);
  assign sh_c = even_clamp({1'b0, src_height_r}, DIM_HI);
  assign st_c = even_clamp(src_stride_r, STRIDE_HI);
  assign dw_c = even_clamp({1'b0, tgt_width_r}, DIM_HI);
  assign dh_c = even_clamp({1'b0, tgt_height_r}, DIM_HI);

  // Raise stride to width, limit target to source
  assign geom.sw = sw_c[DIM_W-1:0];
  assign geom.sh = sh_c[DIM_W-1:0];
  assign geom.st = (st_c < sw_c) ? sw_c : st_c;
  assign geom.dw = (dw_c > sw_c) ? sw_c[DIM_W-1:0] : dw_c[DIM_W-1:0];
  assign geom.dh = (dh_c > sh_c) ? sh_c[DIM_W-1:0] : dh_c[DIM_W-1:0];

  ndsc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .geom           (geom),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_in    (in_pixel_in),
    .in_frame_start (in_frame_start),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .queue_full     (queue_full),
    .push           (push),
    .push_word      (push_word)
  );

  ndsc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  ndsc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .full      (queue_full),
    .pop       (pop),
    .empty     (queue_empty),
    .head      (head)
  );

  ndsc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .empty          (queue_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_plane_out  (out_plane_out),
    .out_frame_last (out_frame_last)
  );

endmodule

// ===== sv/ndsc_checker.sv =====
// Port-level checker for the downscaler, bound to the top level.
`include "yuv420_nearest_downscaler_unit_macros.svh"

module ndsc_checker import ndsc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [PIX_W-1:0]   out_pixel_out,
  input logic [PLANE_W-1:0] out_plane_out,
  input logic               out_frame_last
);

  // Result channel holds a stalled word
  `NDSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out word dropped")
  `NDSC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_pixel_out) && $stable(out_plane_out) && $stable(out_frame_last), "out word changed")

  // Frame end only marks a V byte
  `NDSC_ASSERT_NOW(a_last_is_v, out_valid && out_frame_last, out_plane_out == PLANE_V, "frame end off V")

  // No word right after reset
  `NDSC_ASSERT_NOW(a_reset_empty, $past(!rst_n), !out_valid, "word after reset")

endmodule

bind yuv420_nearest_downscaler_unit ndsc_checker u_ndsc_checker (.*);
